FILE: src/lnws_pkg.sv
// Shared types and constants for the 4-bit LCD write sequencer.
// Holds the microcode word layout, command codes and program entry points.
// No dependencies.
`default_nettype none

package lnws_pkg;

  // Item command codes
  typedef enum logic [1:0] {
    CMD_COMMAND = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_INIT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Program counter width and program layout
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] ENTRY_COMMAND = STEP_W'(0);
  localparam logic [STEP_W-1:0] ENTRY_DATA    = STEP_W'(4);
  localparam logic [STEP_W-1:0] ENTRY_INIT    = STEP_W'(8);

  // Fixed timings in microseconds
  localparam logic [15:0] CMD_GAP_US   = 16'd5;
  localparam logic [15:0] DATA_HOLD_US = 16'd40;
  localparam logic [15:0] POWERUP_US   = 16'd50000;

  // Reset value of the reverse-lines register
  localparam logic REVERSE_RESET = 1'b1;

  // Where the nibble of a pin state comes from
  typedef enum logic [1:0] {
    NIB_HIGH  = 2'd0,
    NIB_LOW   = 2'd1,
    NIB_CONST = 2'd2
  } nib_sel_t;

  // Where the hold time of a pin state comes from
  typedef enum logic {
    HOLD_ITEM  = 1'b0,
    HOLD_CONST = 1'b1
  } hold_sel_t;

  // One microcode word: one pin state
  typedef struct packed {
    logic        rs;
    logic        en;
    nib_sel_t    nib_sel;
    logic [3:0]  nib;
    hold_sel_t   hold_sel;
    logic [15:0] hold;
    logic        last;
  } ucode_word_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic        load_item;
    logic        step;
    ucode_word_t word;
  } dp_ctrl_t;

endpackage

`default_nettype wire

FILE: src/lnws_ucode_rom.sv
// Microcode program ROM: one control word per pin state.
// Programs for command write, data write and power-up init. Uses lnws_pkg.
`default_nettype none

module lnws_ucode_rom
  import lnws_pkg::*;
(
  input  wire logic [STEP_W-1:0] pc,
  output ucode_word_t            word
);

  function automatic ucode_word_t mk(logic rs, logic en, nib_sel_t ns, logic [3:0] nib,
                                     hold_sel_t hs, logic [15:0] hold, logic last);
    ucode_word_t w;
    w.rs       = rs;
    w.en       = en;
    w.nib_sel  = ns;
    w.nib      = nib;
    w.hold_sel = hs;
    w.hold     = hold;
    w.last     = last;
    return w;
  endfunction

  // Program table
  always_comb begin
    unique case (pc)
      // command write: item hold with enable high, 5 us gap after
      6'd0:  word = mk(1'b0, 1'b1, NIB_HIGH, 4'h0, HOLD_ITEM, 16'd0, 1'b0);
      6'd1:  word = mk(1'b0, 1'b0, NIB_HIGH, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd2:  word = mk(1'b0, 1'b1, NIB_LOW, 4'h0, HOLD_ITEM, 16'd0, 1'b0);
      6'd3:  word = mk(1'b0, 1'b0, NIB_LOW, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b1);
      // data write: fixed 40 us enable, no gap
      6'd4:  word = mk(1'b1, 1'b1, NIB_HIGH, 4'h0, HOLD_CONST, DATA_HOLD_US, 1'b0);
      6'd5:  word = mk(1'b1, 1'b0, NIB_HIGH, 4'h0, HOLD_CONST, 16'd0, 1'b0);
      6'd6:  word = mk(1'b1, 1'b1, NIB_LOW, 4'h0, HOLD_CONST, DATA_HOLD_US, 1'b0);
      6'd7:  word = mk(1'b1, 1'b0, NIB_LOW, 4'h0, HOLD_CONST, 16'd0, 1'b1);
      // init: power-up wait
      6'd8:  word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, POWERUP_US, 1'b0);
      // function set, 4-bit (0x20)
      6'd9:  word = mk(1'b0, 1'b1, NIB_CONST, 4'h2, HOLD_CONST, 16'd40, 1'b0);
      6'd10: word = mk(1'b0, 1'b0, NIB_CONST, 4'h2, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd11: word = mk(1'b0, 1'b1, NIB_CONST, 4'h0, HOLD_CONST, 16'd40, 1'b0);
      6'd12: word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b0);
      // raw 0x3 nibble
      6'd13: word = mk(1'b0, 1'b1, NIB_CONST, 4'h3, HOLD_CONST, 16'd40, 1'b0);
      6'd14: word = mk(1'b0, 1'b0, NIB_CONST, 4'h3, HOLD_CONST, 16'd0, 1'b0);
      // function set, 2 lines, 5x8 (0x28)
      6'd15: word = mk(1'b0, 1'b1, NIB_CONST, 4'h2, HOLD_CONST, 16'd40, 1'b0);
      6'd16: word = mk(1'b0, 1'b0, NIB_CONST, 4'h2, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd17: word = mk(1'b0, 1'b1, NIB_CONST, 4'h8, HOLD_CONST, 16'd40, 1'b0);
      6'd18: word = mk(1'b0, 1'b0, NIB_CONST, 4'h8, HOLD_CONST, CMD_GAP_US, 1'b0);
      // display on (0x0C)
      6'd19: word = mk(1'b0, 1'b1, NIB_CONST, 4'h0, HOLD_CONST, 16'd38, 1'b0);
      6'd20: word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd21: word = mk(1'b0, 1'b1, NIB_CONST, 4'hC, HOLD_CONST, 16'd38, 1'b0);
      6'd22: word = mk(1'b0, 1'b0, NIB_CONST, 4'hC, HOLD_CONST, CMD_GAP_US, 1'b0);
      // clear (0x01)
      6'd23: word = mk(1'b0, 1'b1, NIB_CONST, 4'h0, HOLD_CONST, 16'd1540, 1'b0);
      6'd24: word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd25: word = mk(1'b0, 1'b1, NIB_CONST, 4'h1, HOLD_CONST, 16'd1540, 1'b0);
      6'd26: word = mk(1'b0, 1'b0, NIB_CONST, 4'h1, HOLD_CONST, CMD_GAP_US, 1'b0);
      // entry mode increment (0x06)
      6'd27: word = mk(1'b0, 1'b1, NIB_CONST, 4'h0, HOLD_CONST, 16'd40, 1'b0);
      6'd28: word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd29: word = mk(1'b0, 1'b1, NIB_CONST, 4'h6, HOLD_CONST, 16'd40, 1'b0);
      6'd30: word = mk(1'b0, 1'b0, NIB_CONST, 4'h6, HOLD_CONST, CMD_GAP_US, 1'b0);
      // return home (0x02)
      6'd31: word = mk(1'b0, 1'b1, NIB_CONST, 4'h0, HOLD_CONST, 16'd1540, 1'b0);
      6'd32: word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, CMD_GAP_US, 1'b0);
      6'd33: word = mk(1'b0, 1'b1, NIB_CONST, 4'h2, HOLD_CONST, 16'd1540, 1'b0);
      6'd34: word = mk(1'b0, 1'b0, NIB_CONST, 4'h2, HOLD_CONST, CMD_GAP_US, 1'b1);
      // unused addresses end the program
      default: word = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_CONST, 16'd0, 1'b1);
    endcase
  end

endmodule

`default_nettype wire

FILE: src/lnws_seq.sv
// Microcode sequencer: step counter, dispatch jump on the item command,
// input handshake. Reads the program ROM. Uses lnws_pkg and lnws_ucode_rom.
`default_nettype none

module lnws_seq
  import lnws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [1:0] cmd,
  input  wire logic       out_free,
  output dp_ctrl_t        ctrl
);

  logic              busy;
  logic              busy_next;
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic [STEP_W-1:0] entry;
  logic              accept;
  logic              step;
  ucode_word_t       word;

  lnws_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  // Dispatch: entry point per command
  always_comb begin
    unique case (cmd_t'(cmd))
      CMD_COMMAND: entry = ENTRY_COMMAND;
      CMD_DATA:    entry = ENTRY_DATA;
      CMD_INIT:    entry = ENTRY_INIT;
      default:     entry = ENTRY_COMMAND;
    endcase
  end

  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;
  assign step       = busy && out_free;

  // Next program counter and run flag; unused command is dropped
  always_comb begin
    busy_next = busy;
    pc_next   = pc;
    if (accept) begin
      busy_next = (cmd_t'(cmd) != CMD_NONE);
      pc_next   = entry;
    end else if (step) begin
      busy_next = !word.last;
      pc_next   = pc + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

  assign ctrl.load_item = accept;
  assign ctrl.step      = step;
  assign ctrl.word      = word;

endmodule

`default_nettype wire

FILE: src/lnws_datapath.sv
// Datapath: item latch, nibble select, pin order mapping, result register.
// Driven by the sequencer control word. Uses lnws_pkg.
`default_nettype none

module lnws_datapath
  import lnws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_ctrl_t    ctrl,
  input  wire logic [7:0]  byte_value,
  input  wire logic [15:0] enable_hold_us,
  input  wire logic        cfg_wen,
  input  wire logic        reverse_data_lines,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             reg_select,
  output logic             enable,
  output logic [3:0]       data_pins,
  output logic [15:0]      hold_us,
  output logic             last
);

  logic [7:0]  byte_q;
  logic [15:0] hold_q;
  logic        reverse;
  logic [3:0]  nib;
  logic [3:0]  pins;
  logic [15:0] hold;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      reverse <= REVERSE_RESET;
    end else if (cfg_wen) begin
      reverse <= reverse_data_lines;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      byte_q <= byte_value;
      hold_q <= enable_hold_us;
    end
  end

  // Nibble and hold selection
  always_comb begin
    unique case (ctrl.word.nib_sel)
      NIB_HIGH: nib = byte_q[7:4];
      NIB_LOW:  nib = byte_q[3:0];
      default:  nib = ctrl.word.nib;
    endcase
    hold = (ctrl.word.hold_sel == HOLD_ITEM) ? hold_q : ctrl.word.hold;
    pins = reverse ? {nib[0], nib[1], nib[2], nib[3]} : nib;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      reg_select <= ctrl.word.rs;
      enable     <= ctrl.word.en;
      data_pins  <= pins;
      hold_us    <= hold;
      last       <= ctrl.word.last;
    end
  end

endmodule

`default_nettype wire

FILE: src/lcd_nibble_write_sequencer.sv
// Top level of the 4-bit character LCD write sequencer.
// Joins the microcode sequencer and the datapath. Uses lnws_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  item     | item_valid / item_ready    | cmd, byte_value, enable_hold_us
//  result   | result_valid / result_ready| reg_select, enable, data_pins, hold_us, last
//  config   | cfg_wen                    | reverse_data_lines
//
// One pin state per cycle leaves the result register while result_ready is high;
// the microcode program sets how many pin states a command write, a data write or
// init produces, and an unused command is dropped.
// A stalled result holds the step counter; the next item is taken once the
// last step is loaded, while that state still waits in the result register.
// Reset is synchronous; it idles the sequencer and sets reverse order.
`default_nettype none

module lcd_nibble_write_sequencer
  import lnws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  byte_value,
  input  wire logic [15:0] enable_hold_us,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             reg_select,
  output logic             enable,
  output logic [3:0]       data_pins,
  output logic [15:0]      hold_us,
  output logic             last,
  input  wire logic        cfg_wen,
  input  wire logic        reverse_data_lines
);

  dp_ctrl_t ctrl;
  logic     out_free;

  assign out_free = !result_valid || result_ready;

  lnws_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .out_free   (out_free),
    .ctrl       (ctrl)
  );

  lnws_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctrl               (ctrl),
    .byte_value         (byte_value),
    .enable_hold_us     (enable_hold_us),
    .cfg_wen            (cfg_wen),
    .reverse_data_lines (reverse_data_lines),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .reg_select         (reg_select),
    .enable             (enable),
    .data_pins          (data_pins),
    .hold_us            (hold_us),
    .last               (last)
  );

endmodule

`default_nettype wire
